// ===== rtl/core/bbct_pkg.sv =====
`timescale 1ns / 1ps
package bbct_pkg;
  localparam int SLOTS_DEF = 64;
  localparam int COUNT_BITS_DEF = 16;
  localparam logic [31:0] UNUSED_TAG = 32'hFFFF_FFFF;

  localparam logic [2:0] F_ACQUIRE = 3'd0;
  localparam logic [2:0] F_RELEASE = 3'd1;
  localparam logic [2:0] F_MARK    = 3'd2;
  localparam logic [2:0] F_FLUSH1  = 3'd3;
  localparam logic [2:0] F_FLUSHA  = 3'd4;
  localparam logic [2:0] F_CLEANUP = 3'd5;
  localparam logic [2:0] F_QUERY   = 3'd6;
  localparam logic [2:0] F_RSVD    = 3'd7;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_UNHELD = 2'd2;

  // byte address of the write_back_mode register
  localparam logic [1:0] CFG_WB_MODE_ADDR = 2'd0;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] unit_id;
    logic [5:0]  slot;
  } in_beat_t;

  typedef struct packed {
    logic [5:0]  slot_out;
    logic [1:0]  status;
    logic        hit;
    logic        fetch;
    logic        wb_req;
    logic [31:0] unit_out;
    logic        last;
  } out_beat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EVAL, S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input beat, reset scan index
    logic eval;     // evaluate read data
    logic advance;  // step scan index
    logic finish;   // build final result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan;     // op walks slots
    logic done;     // scan complete (stop or end)
    logic emit;     // a result is ready in the datapath
  } sts_t;
endpackage

// ===== rtl/core/bbct_ram.sv =====
`timescale 1ns / 1ps
module bbct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/bbct_datapath.sv =====
`timescale 1ns / 1ps
module bbct_datapath #(
  parameter int SLOTS = bbct_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = bbct_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bbct_pkg::cmd_t      cmd,
  output bbct_pkg::sts_t      sts,
  input  bbct_pkg::in_beat_t  in_beat,
  input  logic                wb_mode,
  output bbct_pkg::out_beat_t res
);
  localparam int IW = $clog2(SLOTS);
  localparam int EW = 32 + COUNT_BITS + 1;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  bbct_pkg::in_beat_t op_r;
  logic [IW:0] idx_r;
  logic [SLOTS-1:0] valid_r;
  logic [EW-1:0] rdata, wdata;
  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [31:0] tag;
  logic [COUNT_BITS-1:0] cnt;
  logic dty;
  logic vld;
  logic in_range;
  logic scan_op;
  logic clr_op;
  logic acq_void;
  logic tag_hit;
  logic slot_free;
  logic found_r, free_r, stop_r;
  logic [IW-1:0] pick_r;      // hit slot or first free slot
  logic hold_v_r;             // write-back held until the next one shows it is not last
  bbct_pkg::out_beat_t hold_r, hold_nxt;
  logic hold_ld;
  logic emit_r, emit_nxt;
  bbct_pkg::out_beat_t res_r, res_nxt;

  assign in_range = {2'b00, op_r.slot} < 8'(SLOTS);
  assign scan_op = op_r.func == bbct_pkg::F_ACQUIRE || op_r.func == bbct_pkg::F_FLUSHA ||
                   op_r.func == bbct_pkg::F_CLEANUP;
  assign clr_op = op_r.func == bbct_pkg::F_CLEANUP;
  assign acq_void = op_r.func == bbct_pkg::F_ACQUIRE && op_r.unit_id == bbct_pkg::UNUSED_TAG;
  assign raddr = scan_op ? idx_r[IW-1:0] : op_r.slot[IW-1:0];
  assign vld = valid_r[raddr];
  assign tag = vld ? rdata[EW-1 -: 32] : bbct_pkg::UNUSED_TAG;
  assign cnt = vld ? rdata[COUNT_BITS:1] : '0;
  assign dty = vld & rdata[0];
  assign tag_hit = tag == op_r.unit_id;
  assign slot_free = cnt == '0 && !dty;

  bbct_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // evaluation of one read slot, and the closing result of a scan
  always_comb begin
    res_nxt = '0;
    emit_nxt = 1'b0;
    hold_nxt = hold_r;
    hold_ld = 1'b0;
    we = 1'b0;
    waddr = raddr;
    wdata = {tag, cnt, dty};
    if (cmd.eval) begin
      case (op_r.func)
        bbct_pkg::F_ACQUIRE: begin
          if (!acq_void && tag_hit) begin
            we = 1'b1;
            wdata = {tag, (cnt < CMAX) ? cnt + 1'b1 : cnt, dty};
          end
        end
        bbct_pkg::F_RELEASE: begin
          if (!in_range || cnt == '0) res_nxt.status = bbct_pkg::ST_UNHELD;
          else begin
            we = 1'b1;
            wdata = {tag, cnt - 1'b1, dty & wb_mode};
            if (!wb_mode && dty) begin
              res_nxt.slot_out = op_r.slot; res_nxt.wb_req = 1'b1; res_nxt.unit_out = tag;
            end
          end
        end
        bbct_pkg::F_MARK: begin
          if (in_range && tag != bbct_pkg::UNUSED_TAG) begin
            we = 1'b1;
            wdata = {tag, cnt, wb_mode};
            if (!wb_mode) begin
              res_nxt.slot_out = op_r.slot; res_nxt.wb_req = 1'b1; res_nxt.unit_out = tag;
            end
          end
        end
        bbct_pkg::F_FLUSH1: begin
          if (in_range && dty) begin
            we = 1'b1; wdata = {tag, cnt, 1'b0};
            res_nxt.slot_out = op_r.slot; res_nxt.wb_req = 1'b1; res_nxt.unit_out = tag;
          end
        end
        bbct_pkg::F_FLUSHA, bbct_pkg::F_CLEANUP: begin
          if (dty) begin
            hold_ld = 1'b1;
            hold_nxt = '0;
            hold_nxt.slot_out = 6'(raddr);
            hold_nxt.wb_req = 1'b1;
            hold_nxt.unit_out = tag;
            if (hold_v_r) begin
              emit_nxt = 1'b1; res_nxt = hold_r;
            end
          end
          we = dty || clr_op;
          wdata = clr_op ? {bbct_pkg::UNUSED_TAG, {COUNT_BITS{1'b0}}, 1'b0} : {tag, cnt, 1'b0};
        end
        bbct_pkg::F_QUERY: res_nxt.unit_out = in_range ? tag : bbct_pkg::UNUSED_TAG;
        default: res_nxt = '0;
      endcase
      if (!scan_op) begin
        emit_nxt = 1'b1;
        res_nxt.last = 1'b1;
        if (!in_range) we = 1'b0;
      end
    end
    if (cmd.finish) begin
      emit_nxt = 1'b1;
      res_nxt = '0;
      if (op_r.func == bbct_pkg::F_ACQUIRE) begin
        if (found_r) begin
          res_nxt.slot_out = 6'(pick_r); res_nxt.hit = 1'b1; res_nxt.unit_out = op_r.unit_id;
        end else if (free_r) begin
          res_nxt.slot_out = 6'(pick_r); res_nxt.fetch = 1'b1; res_nxt.unit_out = op_r.unit_id;
          we = 1'b1;
          waddr = pick_r;
          wdata = {op_r.unit_id, CNT_ONE, 1'b0};
        end else res_nxt.status = bbct_pkg::ST_FULL;
      end else if (hold_v_r) res_nxt = hold_r;
      res_nxt.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      emit_r <= 1'b0;
      idx_r <= '0;
      hold_v_r <= 1'b0;
      found_r <= 1'b0;
      free_r <= 1'b0;
      stop_r <= 1'b0;
    end else begin
      emit_r <= emit_nxt;
      if (we) valid_r[waddr] <= 1'b1;
      if (cmd.load) idx_r <= '0;
      else if (cmd.advance) idx_r <= idx_r + 1'b1;
      if (cmd.load) hold_v_r <= 1'b0;
      else if (hold_ld) hold_v_r <= 1'b1;
      if (cmd.load) begin
        found_r <= 1'b0; free_r <= 1'b0; stop_r <= 1'b0;
      end else if (cmd.eval && op_r.func == bbct_pkg::F_ACQUIRE) begin
        if (tag_hit) begin
          found_r <= 1'b1; stop_r <= 1'b1;
        end else begin
          if (!free_r && slot_free) free_r <= 1'b1;
          if (tag == bbct_pkg::UNUSED_TAG) stop_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) op_r <= in_beat;
    if (hold_ld) hold_r <= hold_nxt;
    res_r <= res_nxt;
    if (cmd.eval && op_r.func == bbct_pkg::F_ACQUIRE) begin
      if (tag_hit || (!free_r && slot_free)) pick_r <= raddr;
    end
  end

  assign sts.scan = scan_op;
  assign sts.done = stop_r || acq_void || idx_r == (IW+1)'(SLOTS);
  assign sts.emit = emit_r;
  assign res = res_r;
endmodule

// ===== rtl/core/block_buffer_cache_tags.sv =====
`timescale 1ns / 1ps
// Sequence: a beat is taken in S_IDLE; a single-slot op reads the RAM in S_READ,
//   evaluates in S_EVAL, and its registered result moves to the output register;
//   acquire/flush-all/cleanup walk slots, a RAM read and an evaluate per slot,
//   then finish in S_EMIT; evaluate and finish wait while output is stalled.
// Flow: one op at a time; in_stall is high until the controller is back in S_IDLE.
// Reset: synchronous active-low; per-slot valid bits make every slot read
//   as unused/clean at once, no clearing pass.
module block_buffer_cache_tags #(
  parameter int SLOTS = bbct_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = bbct_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bbct_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bbct_pkg::out_beat_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic wb_mode_r;
  assign pready = 1'b1;
  assign prdata = (paddr == bbct_pkg::CFG_WB_MODE_ADDR) ? {31'd0, wb_mode_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) wb_mode_r <= 1'b0;
    else if (psel && penable && pwrite && paddr == bbct_pkg::CFG_WB_MODE_ADDR)
      wb_mode_r <= pwdata[0];
  end

  bbct_pkg::cmd_t cmd;
  bbct_pkg::sts_t sts;
  bbct_pkg::out_beat_t res;
  bbct_pkg::state_t state_r, state_nxt;
  logic obuf_v_r;
  bbct_pkg::out_beat_t obuf_r;

  // output register; holds while stalled
  assign out_valid = obuf_v_r;
  assign out_data = obuf_r;
  always_ff @(posedge clk) begin
    if (!rst_n) obuf_v_r <= 1'b0;
    else if (sts.emit) obuf_v_r <= 1'b1;
    else if (!out_stall) obuf_v_r <= 1'b0;
    if (sts.emit) obuf_r <= res;
  end

  // controller: only evaluate or finish when the output register can take a beat
  logic room;
  assign room = !obuf_v_r || !out_stall;
  assign in_stall = state_r != bbct_pkg::S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= bbct_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bbct_pkg::S_IDLE: if (in_valid) state_nxt = bbct_pkg::S_READ;
      bbct_pkg::S_READ: begin
        if (sts.scan && sts.done) state_nxt = bbct_pkg::S_EMIT;
        else state_nxt = bbct_pkg::S_EVAL;
      end
      bbct_pkg::S_EVAL: if (room && !sts.emit) state_nxt =
          sts.scan ? bbct_pkg::S_READ : bbct_pkg::S_IDLE;
      bbct_pkg::S_EMIT: if (room && !sts.emit) state_nxt = bbct_pkg::S_IDLE;
      default: state_nxt = bbct_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      bbct_pkg::S_IDLE: cmd.load = in_valid;
      bbct_pkg::S_EVAL: if (room && !sts.emit) begin
        cmd.eval = 1'b1; cmd.advance = 1'b1;
      end
      bbct_pkg::S_EMIT: cmd.finish = room && !sts.emit;
      default: cmd = '0;
    endcase
  end

  bbct_datapath #(.SLOTS(SLOTS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_beat(in_data),
    .wb_mode(wb_mode_r), .res(res)
  );

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == bbct_pkg::S_IDLE) else $error("load outside idle");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval || cmd.finish) |-> room) else $error("eval without room");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.eval, cmd.finish})) else $error("cmd clash");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("beat dropped");
endmodule
